>>> src/uam_pkg.sv
`timescale 1ns / 1ps

package uam_pkg;

	localparam int ROW_MAX = 64;
	localparam int VTX_W = 6;
	localparam int CNT_W = 7;
	localparam int VAL_W = 11;
	localparam int OPC_W = 3;

	localparam logic [OPC_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OPC_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OPC_W-1:0] OP_CHECK  = 3'd2;
	localparam logic [OPC_W-1:0] OP_DEGREE = 3'd3;
	localparam logic [OPC_W-1:0] OP_NEIGH  = 3'd4;
	localparam logic [OPC_W-1:0] OP_COUNT  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [VTX_W-1:0] first_vertex;
		logic [VTX_W-1:0] second_vertex;
	} req_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [1:0]       status;
		logic             last;
	} rsp_item_t;

	typedef enum logic [2:0] {
		K_ZERO   = 3'd0,
		K_RANGE  = 3'd1,
		K_EMPTY  = 3'd2,
		K_CHECK  = 3'd3,
		K_DEGREE = 3'd4,
		K_NEIGH  = 3'd5,
		K_COUNT  = 3'd6
	} rsp_kind_t;

	typedef enum logic [1:0] {
		RS_NONE = 2'd0,
		RS_A    = 2'd1,
		RS_B    = 2'd2,
		RS_IDX  = 2'd3
	} rd_sel_t;

	typedef struct packed {
		logic      capture;
		rd_sel_t   rd_sel;
		logic      wr_en;
		logic      wr_sel_b;
		logic      emit;
		rsp_kind_t kind;
		logic      scan_load;
		logic      scan_shift;
		logic      ec_start;
		logic      ec_issue;
	} cmd_t;

	typedef struct packed {
		logic [OPC_W-1:0] op;
		logic             a_ok;
		logic             pair_ok;
		logic             n_zero;
		logic             row_zero;
		logic             bit0;
		logic             rest_zero;
		logic             ec_last;
		logic             out_free;
	} sts_t;

	function automatic logic [CNT_W-1:0] popcnt64(input logic [ROW_MAX-1:0] x);
		logic [CNT_W-1:0] s [ROW_MAX];
		for (int j = 0; j < ROW_MAX; j++) begin
			s[j] = CNT_W'(x[j]);
		end
		for (int lvl = 1; lvl <= 6; lvl++) begin
			for (int j = 0; j < (ROW_MAX >> lvl); j++) begin
				s[j] = s[2*j] + s[2*j+1];
			end
		end
		return s[0];
	endfunction

endpackage

>>> src/uam_ram.sv
`timescale 1ns / 1ps

module uam_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/uam_dp.sv
`timescale 1ns / 1ps

module uam_dp #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [uam_pkg::CNT_W-1:0]  cfg_wdata,
	input  uam_pkg::req_item_t         req,
	input  uam_pkg::cmd_t              cmd,
	output uam_pkg::sts_t              sts,
	output uam_pkg::rsp_item_t         rsp,
	output logic                       rsp_valid,
	input  logic                       rsp_ready
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = uam_pkg::CNT_W;

	logic [CW-1:0]                 n_q;
	logic [CW-1:0]                 n_eff;
	uam_pkg::req_item_t            item_q;
	logic [MAX_VERTICES-1:0]       valid_q;
	logic                          rvalid_s1;
	logic [MAX_VERTICES-1:0]       ram_rdata;
	logic [MAX_VERTICES-1:0]       row;
	logic [MAX_VERTICES-1:0]       act;
	logic [MAX_VERTICES-1:0]       wr_row;
	logic [AW-1:0]                 a_idx;
	logic [AW-1:0]                 b_idx;
	logic [AW-1:0]                 waddr;
	logic [AW-1:0]                 raddr;
	logic                          re;
	logic [MAX_VERTICES-1:0]       scan_q;
	logic [AW-1:0]                 nb_i_q;
	logic [CW-1:0]                 ec_i_q;
	logic [MAX_VERTICES-1:0]       upper_q;
	logic                          ec_v_s1;
	logic [MAX_VERTICES-1:0]       upper_s1;
	logic                          ec_v_s2;
	logic [CW-1:0]                 cnt_s2;
	logic [uam_pkg::VAL_W-1:0]     acc_q;
	uam_pkg::rsp_item_t            rsp_q;
	uam_pkg::rsp_item_t            rsp_d;
	logic                          rsp_valid_q;

	assign n_eff = (n_q > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : n_q;
	assign a_idx = item_q.first_vertex[AW-1:0];
	assign b_idx = item_q.second_vertex[AW-1:0];

	always_comb begin
		for (int c = 0; c < MAX_VERTICES; c++) begin
			act[c] = (CW'(c) < n_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cfg_we) begin
			n_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
	end

	always_comb begin
		re = 1'b1;
		unique case (cmd.rd_sel)
			uam_pkg::RS_A:   raddr = a_idx;
			uam_pkg::RS_B:   raddr = b_idx;
			uam_pkg::RS_IDX: raddr = ec_i_q[AW-1:0];
			default: begin
				raddr = a_idx;
				re = 1'b0;
			end
		endcase
	end

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rvalid_s1 <= valid_q[raddr];
		end
	end

	uam_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wr_row),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign row = ram_rdata & {MAX_VERTICES{rvalid_s1}};

	always_comb begin
		waddr = cmd.wr_sel_b ? b_idx : a_idx;
		wr_row = row;
		wr_row[cmd.wr_sel_b ? a_idx : b_idx] = (item_q.opcode == uam_pkg::OP_ADD);
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_load) begin
			scan_q <= row & act;
			nb_i_q <= '0;
		end else if (cmd.scan_shift) begin
			scan_q <= scan_q >> 1;
			nb_i_q <= nb_i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ec_start) begin
			ec_i_q <= '0;
			upper_q <= {{(MAX_VERTICES-1){1'b1}}, 1'b0};
		end else if (cmd.ec_issue) begin
			ec_i_q <= ec_i_q + 1'b1;
			upper_q <= upper_q << 1;
		end
		upper_s1 <= upper_q;
		cnt_s2 <= uam_pkg::popcnt64(uam_pkg::ROW_MAX'(row & act & upper_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_v_s1 <= 1'b0;
			ec_v_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			ec_v_s1 <= cmd.ec_issue;
			ec_v_s2 <= ec_v_s1;
			if (cmd.ec_start) begin
				acc_q <= '0;
			end else if (ec_v_s2) begin
				acc_q <= acc_q + uam_pkg::VAL_W'(cnt_s2);
			end
		end
	end

	always_comb begin
		rsp_d.value = '0;
		rsp_d.status = uam_pkg::ST_OK;
		rsp_d.last = 1'b1;
		unique case (cmd.kind)
			uam_pkg::K_RANGE: rsp_d.status = uam_pkg::ST_RANGE;
			uam_pkg::K_EMPTY: rsp_d.status = uam_pkg::ST_EMPTY;
			uam_pkg::K_CHECK: rsp_d.value = uam_pkg::VAL_W'(row[b_idx]);
			uam_pkg::K_DEGREE: begin
				rsp_d.value = uam_pkg::VAL_W'(
					uam_pkg::popcnt64(uam_pkg::ROW_MAX'(row & act)));
			end
			uam_pkg::K_NEIGH: begin
				rsp_d.value = uam_pkg::VAL_W'(nb_i_q);
				rsp_d.last = sts.rest_zero;
			end
			uam_pkg::K_COUNT: rsp_d.value = acc_q;
			default: rsp_d.value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.op        = item_q.opcode;
	assign sts.a_ok      = {1'b0, item_q.first_vertex} < n_eff;
	assign sts.pair_ok   = sts.a_ok && ({1'b0, item_q.second_vertex} < n_eff);
	assign sts.n_zero    = (n_eff == '0);
	assign sts.row_zero  = ((row & act) == '0);
	assign sts.bit0      = scan_q[0];
	assign sts.rest_zero = (scan_q[MAX_VERTICES-1:1] == '0);
	assign sts.ec_last   = ((ec_i_q + 1'b1) == n_eff);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

endmodule

>>> src/uam_ctrl.sv
`timescale 1ns / 1ps

module uam_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  uam_pkg::sts_t sts,
	output uam_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_DISP  = 11'b000_0000_0010,
		S_RD_A  = 11'b000_0000_0100,
		S_USE_A = 11'b000_0000_1000,
		S_RD_B  = 11'b000_0001_0000,
		S_USE_B = 11'b000_0010_0000,
		S_SCAN  = 11'b000_0100_0000,
		S_EC_RD = 11'b000_1000_0000,
		S_EC_D1 = 11'b001_0000_0000,
		S_EC_D2 = 11'b010_0000_0000,
		S_EMIT  = 11'b100_0000_0000
	} state_t;

	state_t              state_q, state_d;
	uam_pkg::rsp_kind_t  kind_q, kind_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op) inside
					uam_pkg::OP_ADD, uam_pkg::OP_REMOVE, uam_pkg::OP_CHECK: begin
						if (sts.pair_ok) begin
							state_d = S_RD_A;
						end else begin
							kind_d = uam_pkg::K_RANGE;
							state_d = S_EMIT;
						end
					end
					uam_pkg::OP_DEGREE, uam_pkg::OP_NEIGH: begin
						if (sts.a_ok) begin
							state_d = S_RD_A;
						end else begin
							kind_d = uam_pkg::K_RANGE;
							state_d = S_EMIT;
						end
					end
					uam_pkg::OP_COUNT: begin
						if (sts.n_zero) begin
							kind_d = uam_pkg::K_ZERO;
							state_d = S_EMIT;
						end else begin
							cmd.ec_start = 1'b1;
							state_d = S_EC_RD;
						end
					end
					default: begin
						kind_d = uam_pkg::K_ZERO;
						state_d = S_EMIT;
					end
				endcase
			end
			S_RD_A: begin
				cmd.rd_sel = uam_pkg::RS_A;
				state_d = S_USE_A;
			end
			S_USE_A: begin
				case (sts.op) inside
					uam_pkg::OP_ADD, uam_pkg::OP_REMOVE: begin
						cmd.wr_en = 1'b1;
						state_d = S_RD_B;
					end
					uam_pkg::OP_CHECK: begin
						cmd.kind = uam_pkg::K_CHECK;
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end
					uam_pkg::OP_DEGREE: begin
						cmd.kind = uam_pkg::K_DEGREE;
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						if (sts.row_zero) begin
							cmd.kind = uam_pkg::K_EMPTY;
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							cmd.scan_load = 1'b1;
							state_d = S_SCAN;
						end
					end
				endcase
			end
			S_RD_B: begin
				cmd.rd_sel = uam_pkg::RS_B;
				state_d = S_USE_B;
			end
			S_USE_B: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel_b = 1'b1;
				kind_d = uam_pkg::K_ZERO;
				state_d = S_EMIT;
			end
			S_SCAN: begin
				cmd.kind = uam_pkg::K_NEIGH;
				if (sts.bit0) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.scan_shift = 1'b1;
						if (sts.rest_zero) begin
							state_d = S_IDLE;
						end
					end
				end else begin
					cmd.scan_shift = 1'b1;
				end
			end
			S_EC_RD: begin
				cmd.rd_sel = uam_pkg::RS_IDX;
				cmd.ec_issue = 1'b1;
				if (sts.ec_last) begin
					state_d = S_EC_D1;
				end
			end
			S_EC_D1: begin
				state_d = S_EC_D2;
			end
			S_EC_D2: begin
				kind_d = uam_pkg::K_COUNT;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.kind = kind_q;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= uam_pkg::K_ZERO;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
		end
	end

endmodule

>>> src/undirected_adjacency_matrix.sv
`timescale 1ns / 1ps

// channel   signals                        transfer when
// req       req_valid, req_ready, req      req_valid && req_ready
// rsp       rsp_valid, rsp_ready, rsp      rsp_valid && rsp_ready
// cfg       cfg_we, cfg_wdata              cfg_we
//
// One item at a time; the matrix RAM (one read and one write port) sets the pace.
// Add/remove rewrite row a, then row b; check/degree read row a; neighbours read
// row a, then scan its columns; edge count reads one row per cycle and sums the
// upper-triangle bits; out-of-range, spare opcodes and a zero count just emit.
// Reset clears per-row valid bits, so the matrix reads as zero at once.
// A result waits in the output register; a new request is taken meanwhile.
// A result blocked by rsp_ready holds the controller until the register frees.

module undirected_adjacency_matrix #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [uam_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  uam_pkg::req_item_t         req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output uam_pkg::rsp_item_t         rsp
);

	uam_pkg::cmd_t cmd;
	uam_pkg::sts_t sts;

	uam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	uam_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import uam_pkg::*;

	localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int MISMATCH_SHOWN = 10;
	localparam int COUNT_TOP = (1 << CNT_W) - 1;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 40;

	typedef struct packed {
		logic             write_cfg;
		logic [CNT_W-1:0] count;
		req_item_t        item;
		logic             typed;
		rsp_item_t        rsp;
	} plan_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_item_t        req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_item_t        rsp;

	logic      req_typed = 1'b0;
	rsp_item_t req_typed_rsp = '0;
	bit        calm = 1'b0;
	int        stall_left = 0;

	logic [ROW_MAX-1:0] adj_model [ROW_MAX];
	logic [CNT_W-1:0]   model_count = '0;
	rsp_item_t          pending_rsp [$];
	plan_row_t          directed_plan [$];
	int mismatches = 0;
	int items_sent = 0;
	int rsp_seen = 0;
	int cfg_writes = 0;

	undirected_adjacency_matrix dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	function automatic void expect_rsp(input int v, input logic [1:0] s, input logic l);
		rsp_item_t e;
		e.value = VAL_W'(v);
		e.status = s;
		e.last = l;
		pending_rsp = {pending_rsp, e};
	endfunction

	function automatic void graph_predict(input req_item_t it);
		int n;
		int total;
		int a;
		int b;
		logic [ROW_MAX-1:0] mask;
		logic [ROW_MAX-1:0] row;
		logic [ROW_MAX-1:0] upper;
		bit a_ok;
		bit pair_ok;
		n = (model_count > ROW_MAX) ? ROW_MAX : int'(model_count);
		mask = (n >= ROW_MAX) ? '1 : ((64'd1 << n) - 64'd1);
		a = int'(it.first_vertex);
		b = int'(it.second_vertex);
		a_ok = a < n;
		pair_ok = a_ok && (b < n);
		case (it.opcode)
			OP_ADD, OP_REMOVE, OP_CHECK: begin
				if (!pair_ok) begin
					expect_rsp(0, ST_RANGE, 1'b1);
				end else if (it.opcode == OP_CHECK) begin
					expect_rsp(int'(adj_model[a][b]), ST_OK, 1'b1);
				end else begin
					adj_model[a][b] = (it.opcode == OP_ADD);
					adj_model[b][a] = (it.opcode == OP_ADD);
					expect_rsp(0, ST_OK, 1'b1);
				end
			end
			OP_DEGREE: begin
				if (!a_ok)
					expect_rsp(0, ST_RANGE, 1'b1);
				else
					expect_rsp($countones(adj_model[a] & mask), ST_OK, 1'b1);
			end
			OP_NEIGH: begin
				row = adj_model[a] & mask;
				if (!a_ok) begin
					expect_rsp(0, ST_RANGE, 1'b1);
				end else if (row == '0) begin
					expect_rsp(0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < n; i++) begin
						if (row[i])
							expect_rsp(i, ST_OK, (row >> (i + 1)) == '0);
					end
				end
			end
			OP_COUNT: begin
				total = 0;
				for (int i = 0; i < n; i++) begin
					upper = ~((64'd2 << i) - 64'd1);
					total += $countones(adj_model[i] & mask & upper);
				end
				expect_rsp(total, ST_OK, 1'b1);
			end
			default: begin
				expect_rsp(0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input rsp_item_t want,
			input rsp_item_t got);
		mismatches++;
		if (mismatches <= MISMATCH_SHOWN)
			$display("%0t %s: expected value %0d status %0d last %0d, got value %0d status %0d last %0d",
				$time, what, want.value, want.status, want.last, got.value, got.status, got.last);
	endfunction

	// predictor tracks transfers; checks every result transfer
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			if (cfg_we)
				model_count = cfg_wdata;
			if (req_valid && req_ready) begin
				graph_predict(req);
				if (req_typed)
					pending_rsp[pending_rsp.size() - 1] = req_typed_rsp;
			end
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (pending_rsp.size() == 0) begin
					note_mismatch("unexpected result", '0, rsp);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.value !== want.value || rsp.status !== want.status ||
							rsp.last !== want.last)
						note_mismatch("result mismatch", want, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				rsp_ready <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			stall_left = $urandom_range(1, 3);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic send_req(input req_item_t it, input logic typed, input rsp_item_t want);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		req_typed <= typed;
		req_typed_rsp <= want;
		items_sent++;
		do begin
			@(posedge clk);
		end while (!req_ready);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		req_typed <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	function automatic void add_row(input int cnt, input logic [OPC_W-1:0] op, input int a,
			input int b, input logic typed, input int v, input logic [1:0] s);
		plan_row_t r;
		r.write_cfg = (cnt >= 0);
		r.count = CNT_W'(cnt);
		r.item.opcode = op;
		r.item.first_vertex = VTX_W'(a);
		r.item.second_vertex = VTX_W'(b);
		r.typed = typed;
		r.rsp.value = VAL_W'(v);
		r.rsp.status = s;
		r.rsp.last = 1'b1;
		directed_plan = {directed_plan, r};
	endfunction

	initial begin
		#(20_000_000);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		plan_row_t r;
		req_item_t it;
		int n_eff;
		int hot;
		int roll;
		logic [CNT_W-1:0] phase_count [PHASES];
		for (int i = 0; i < ROW_MAX; i++)
			adj_model[i] = '0;

		// count is zero out of reset
		add_row(-1, OP_ADD, 0, 0, 1'b1, 0, ST_RANGE);
		add_row(-1, OP_CHECK, 63, 63, 1'b1, 0, ST_RANGE);
		add_row(-1, OP_NEIGH, 0, 0, 1'b1, 0, ST_RANGE);
		add_row(-1, OP_COUNT, 0, 0, 1'b1, 0, ST_OK);
		// count above the maximum clamps
		add_row(COUNT_TOP, OP_ADD, 0, 63, 1'b1, 0, ST_OK);
		add_row(-1, OP_ADD, 63, 63, 1'b1, 0, ST_OK);
		add_row(-1, OP_ADD, 0, 0, 1'b1, 0, ST_OK);
		add_row(-1, OP_ADD, 5, 40, 1'b1, 0, ST_OK);
		add_row(-1, OP_CHECK, 63, 0, 1'b1, 1, ST_OK);
		add_row(-1, OP_DEGREE, 0, 0, 1'b1, 2, ST_OK);
		add_row(-1, OP_DEGREE, 63, 0, 1'b1, 2, ST_OK);
		add_row(-1, OP_NEIGH, 0, 0, 1'b0, 0, ST_OK);
		add_row(-1, OP_NEIGH, 1, 0, 1'b1, 0, ST_EMPTY);
		add_row(-1, OP_COUNT, 0, 0, 1'b0, 0, ST_OK);
		add_row(-1, OP_SPARE_HI, 63, 63, 1'b1, 0, ST_OK);
		add_row(-1, OP_REMOVE, 63, 0, 1'b1, 0, ST_OK);
		add_row(-1, OP_CHECK, 0, 63, 1'b1, 0, ST_OK);
		// shrinking the count hides bits without clearing them
		add_row(40, OP_CHECK, 5, 40, 1'b1, 0, ST_RANGE);
		add_row(-1, OP_REMOVE, 40, 5, 1'b1, 0, ST_RANGE);
		add_row(-1, OP_DEGREE, 5, 0, 1'b1, 0, ST_OK);
		add_row(-1, OP_NEIGH, 5, 0, 1'b1, 0, ST_EMPTY);
		add_row(ROW_MAX, OP_CHECK, 40, 5, 1'b1, 1, ST_OK);
		add_row(1, OP_DEGREE, 0, 0, 1'b1, 1, ST_OK);
		add_row(-1, OP_DEGREE, 1, 0, 1'b1, 0, ST_RANGE);
		add_row(0, OP_SPARE_LO, 0, 0, 1'b1, 0, ST_OK);

		phase_count[0] = CNT_W'(ROW_MAX);
		phase_count[1] = CNT_W'($urandom_range(3, ROW_MAX - 1));
		phase_count[2] = CNT_W'(2);
		phase_count[3] = CNT_W'($urandom_range(ROW_MAX + 1, COUNT_TOP));
		phase_count[4] = CNT_W'($urandom_range(8, ROW_MAX));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[k]) begin
			r = directed_plan[k];
			if (r.write_cfg)
				write_count(r.count);
			send_req(r.item, r.typed, r.rsp);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_count(phase_count[p]);
			calm = (p == PHASES - 1);
			n_eff = (phase_count[p] > ROW_MAX) ? ROW_MAX : int'(phase_count[p]);
			hot = (n_eff < 8) ? n_eff : 8;
			repeat (PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 35)
					it.opcode = OP_ADD;
				else if (roll < 45)
					it.opcode = OP_REMOVE;
				else if (roll < 60)
					it.opcode = OP_CHECK;
				else if (roll < 70)
					it.opcode = OP_DEGREE;
				else if (roll < 85)
					it.opcode = OP_NEIGH;
				else if (roll < 95)
					it.opcode = OP_COUNT;
				else
					it.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
				// mostly in-range endpoints, often from a small hot set
				roll = $urandom_range(0, 99);
				if (roll < 12)
					it.first_vertex = VTX_W'($urandom_range(0, ROW_MAX - 1));
				else if (roll < 55)
					it.first_vertex = VTX_W'($urandom_range(0, hot - 1));
				else
					it.first_vertex = VTX_W'($urandom_range(0, n_eff - 1));
				roll = $urandom_range(0, 99);
				if (roll < 12)
					it.second_vertex = VTX_W'($urandom_range(0, ROW_MAX - 1));
				else if (roll < 55)
					it.second_vertex = VTX_W'($urandom_range(0, hot - 1));
				else
					it.second_vertex = VTX_W'($urandom_range(0, n_eff - 1));
				send_req(it, 1'b0, '0);
			end
		end

		settle();
		$display("%0d requests over %0d vertex count settings, %0d results compared, %0d mismatches",
			items_sent, cfg_writes, rsp_seen, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
